### src/hkr_pkg.sv
// ----------------------------------------------------------------------------
// hkr_pkg: shared types and constants for the held key repeat controller
// Op codes, contexts, key classes, list selects and the item structs.
// ----------------------------------------------------------------------------
package hkr_pkg;

    localparam int DEF_MOVE_KEYS    = 8;
    localparam int DEF_MENU_KEYS    = 8;
    localparam int DEF_BLOCKED_KEYS = 8;

    localparam logic [15:0] RST_MOVE_FIRST = 16'd250;
    localparam logic [15:0] RST_MENU_FIRST = 16'd300;
    localparam logic [15:0] RST_MENU_GAP   = 16'd80;

    localparam logic [1:0] REG_MOVE_FIRST = 2'd0;
    localparam logic [1:0] REG_MENU_FIRST = 2'd1;
    localparam logic [1:0] REG_MENU_GAP   = 2'd2;

    localparam logic [2:0] OP_FRAME    = 3'd0;
    localparam logic [2:0] OP_SET_CTX  = 3'd1;
    localparam logic [2:0] OP_KEY_DOWN = 3'd2;
    localparam logic [2:0] OP_KEY_UP   = 3'd3;
    localparam logic [2:0] OP_POLL     = 3'd4;
    localparam logic [2:0] OP_WAIT     = 3'd5;
    localparam logic [2:0] OP_CONTROLS = 3'd6;

    localparam logic [2:0] CTX_NONE   = 3'd0;
    localparam logic [2:0] CTX_MOVE   = 3'd1;
    localparam logic [2:0] CTX_BATTLE = 3'd2;
    localparam logic [2:0] CTX_MENU   = 3'd3;
    localparam logic [2:0] CTX_SAVE   = 3'd4;

    localparam logic [1:0] CLS_OTHER    = 2'd0;
    localparam logic [1:0] CLS_CARDINAL = 2'd1;
    localparam logic [1:0] CLS_PAGE     = 2'd2;
    localparam logic [1:0] CLS_HOME_END = 2'd3;

    localparam logic [1:0] LST_MOVE = 2'd0;
    localparam logic [1:0] LST_MENU = 2'd1;
    localparam logic [1:0] LST_BLK  = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  key_code;
        logic [1:0]  key_class;
        logic        auto_repeat;
        logic [2:0]  new_context;
        logic [31:0] now_ms;
    } req_t;

    typedef struct packed {
        logic        accepted;
        logic        move_repeat_valid;
        logic        menu_repeat_valid;
        logic [7:0]  repeat_key;
        logic        wait_valid;
        logic [31:0] wait_ms;
    } rsp_t;

    function automatic logic is_move_ctx(input logic [2:0] c);
        return (c == CTX_MOVE) || (c == CTX_BATTLE);
    endfunction

    function automatic logic is_menu_ctx(input logic [2:0] c);
        return (c == CTX_MENU) || (c == CTX_SAVE);
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] d);
        logic [32:0] s;
        s = {1'b0, a} + {17'd0, d};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

### src/held_key_repeat_controller.sv
// ----------------------------------------------------------------------------
// held_key_repeat_controller: typematic repeat for held direction keys
// Movement stack, menu stack and blocked list walked one entry a cycle.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req     | in  | req_valid/req_ready  | req (op, key, class, repeat, ctx, time)
//  rsp     | out | rsp_valid/rsp_ready  | rsp (accepted, repeat flags, key, wait)
//  cfg     | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data (16 bit delays)
//
//  A simple op passes through decode, result and idle; every list pass walks
//  the list's entries one by one and then returns to the sequencer. A context
//  change that blocks held keys scans the blocked list for each key and pushes it.
//  A single list scan/shift unit serves every list. req_ready is high only
//  while idle; a finished item waits in the rsp register until taken.
//  Reset empties all lists, selects no context and loads the default delays.
module held_key_repeat_controller
    import hkr_pkg::*;
#(
    parameter int MOVE_KEYS    = DEF_MOVE_KEYS,
    parameter int MENU_KEYS    = DEF_MENU_KEYS,
    parameter int BLOCKED_KEYS = DEF_BLOCKED_KEYS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_t        rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int MAXK = (MOVE_KEYS > MENU_KEYS) ?
        ((MOVE_KEYS > BLOCKED_KEYS) ? MOVE_KEYS : BLOCKED_KEYS) :
        ((MENU_KEYS > BLOCKED_KEYS) ? MENU_KEYS : BLOCKED_KEYS);
    localparam int CW  = $clog2(MAXK + 1);
    localparam int MVW = (MOVE_KEYS > 1) ? $clog2(MOVE_KEYS) : 1;
    localparam int MNW = (MENU_KEYS > 1) ? $clog2(MENU_KEYS) : 1;
    localparam int BLW = (BLOCKED_KEYS > 1) ? $clog2(BLOCKED_KEYS) : 1;
    localparam logic [CW-1:0] MOVE_CAP = CW'(MOVE_KEYS);
    localparam logic [CW-1:0] MENU_CAP = CW'(MENU_KEYS);
    localparam logic [CW-1:0] BLK_CAP  = CW'(BLOCKED_KEYS);

    // sequencer steps within one op
    localparam logic [2:0] P_START = 3'd0;
    localparam logic [2:0] P_1     = 3'd1;
    localparam logic [2:0] P_2     = 3'd2;
    localparam logic [2:0] P_3     = 3'd3;
    localparam logic [2:0] P_4     = 3'd4;
    localparam logic [2:0] P_5     = 3'd5;
    localparam logic [2:0] P_6     = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CTRL = 4'b0010,
        S_SCAN = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    req_t        req_reg, req_next;
    rsp_t        rsp_reg, rsp_next;
    logic [7:0]  key_reg, key_next;
    logic [2:0]  ph_reg, ph_next;
    logic [1:0]  sel_reg, sel_next;
    logic [1:0]  src_reg, src_next;
    logic        drop_reg, drop_next;
    logic        found_reg, found_next;
    logic        top_reg, top_next;
    logic        first_reg, first_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] move_n_reg, move_n_next;
    logic [CW-1:0] menu_n_reg, menu_n_next;
    logic [CW-1:0] blk_n_reg, blk_n_next;
    logic [2:0]  ctx_reg, ctx_next;
    logic [31:0] move_due_reg, move_due_next;
    logic [31:0] menu_due_reg, menu_due_next;
    logic        mflag_reg, mflag_next;
    logic        nflag_reg, nflag_next;
    logic [15:0] move_first_reg, menu_first_reg, menu_gap_reg;

    logic [7:0] move_mem [MOVE_KEYS];
    logic [7:0] menu_mem [MENU_KEYS];
    logic [7:0] blk_mem  [BLOCKED_KEYS];

    // single read port per list, shared by scan, block walk and poll
    logic [1:0]    rd_sel;
    logic [CW-1:0] rd_addr;
    logic [7:0]    rd_data, mv_rd, mn_rd, bl_rd;

    logic          wr_en, wr2_en;
    logic [1:0]    wr_sel;
    logic [CW-1:0] wr_addr, wr2_addr;
    logic [7:0]    wr_data, wr2_data;

    logic          go_scan, go_drop;
    logic [1:0]    go_sel;
    logic          done;
    rsp_t          res;
    logic [CW-1:0] sel_cnt, src_cnt;
    logic          ctl;
    logic [2:0]    c_new;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_OUT);
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;
    assign c_new     = req_reg.new_context;

    assign mv_rd = move_mem[rd_addr[MVW-1:0]];
    assign mn_rd = menu_mem[rd_addr[MNW-1:0]];
    assign bl_rd = blk_mem[rd_addr[BLW-1:0]];

    always_comb
    begin
        case (rd_sel)
            LST_MOVE: rd_data = mv_rd;
            LST_MENU: rd_data = mn_rd;
            default:  rd_data = bl_rd;
        endcase
    end

    always_comb
    begin
        case (sel_reg)
            LST_MOVE: sel_cnt = move_n_reg;
            LST_MENU: sel_cnt = menu_n_reg;
            default:  sel_cnt = blk_n_reg;
        endcase
        src_cnt = (src_reg == LST_MOVE) ? move_n_reg : menu_n_reg;
    end

    // controls: does the key class repeat in the current context
    always_comb
    begin
        if (is_move_ctx(ctx_reg))
        begin
            ctl = (req_reg.key_class != CLS_OTHER);
        end
        else if (is_menu_ctx(ctx_reg))
        begin
            ctl = (req_reg.key_class == CLS_CARDINAL) || (req_reg.key_class == CLS_PAGE);
        end
        else
        begin
            ctl = 1'b0;
        end
    end

    // read address: scan walks idx, block walk uses j, otherwise read the top
    always_comb
    begin
        if (state_reg == S_SCAN)
        begin
            rd_sel  = sel_reg;
            rd_addr = idx_reg;
        end
        else if (req_reg.op == OP_SET_CTX)
        begin
            rd_sel  = src_reg;
            rd_addr = j_reg;
        end
        else if (req_reg.op == OP_POLL && is_menu_ctx(ctx_reg))
        begin
            rd_sel  = LST_MENU;
            rd_addr = menu_n_reg - 1'b1;
        end
        else
        begin
            rd_sel  = LST_MOVE;
            rd_addr = move_n_reg - 1'b1;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        rsp_next      = rsp_reg;
        key_next      = key_reg;
        ph_next       = ph_reg;
        sel_next      = sel_reg;
        src_next      = src_reg;
        drop_next     = drop_reg;
        found_next    = found_reg;
        top_next      = top_reg;
        first_next    = first_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        j_next        = j_reg;
        move_n_next   = move_n_reg;
        menu_n_next   = menu_n_reg;
        blk_n_next    = blk_n_reg;
        ctx_next      = ctx_reg;
        move_due_next = move_due_reg;
        menu_due_next = menu_due_reg;
        mflag_next    = mflag_reg;
        nflag_next    = nflag_reg;
        wr_en         = 1'b0;
        wr_sel        = LST_MOVE;
        wr_addr       = '0;
        wr_data       = key_reg;
        wr2_en        = 1'b0;
        wr2_addr      = '0;
        wr2_data      = rd_data;
        go_scan       = 1'b0;
        go_drop       = 1'b0;
        go_sel        = LST_MOVE;
        done          = 1'b0;
        res           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    key_next   = req.key_code;
                    ph_next    = P_START;
                    state_next = S_CTRL;
                end
            end

            S_CTRL:
            begin
                case (req_reg.op)
                    OP_FRAME:
                    begin
                        mflag_next = 1'b0;
                        nflag_next = 1'b0;
                        done       = 1'b1;
                    end

                    OP_SET_CTX:
                    begin
                        case (ph_reg)
                            P_START:
                            begin
                                if (c_new > CTX_SAVE || c_new == ctx_reg)
                                begin
                                    done = 1'b1;
                                end
                                else if (is_menu_ctx(ctx_reg) && is_menu_ctx(c_new))
                                begin
                                    ctx_next = c_new;
                                    done     = 1'b1;
                                end
                                else if (is_move_ctx(ctx_reg))
                                begin
                                    if (ctx_reg == CTX_MOVE && c_new == CTX_NONE)
                                    begin
                                        if (move_n_reg != '0)
                                        begin
                                            move_due_next = sat_add(req_reg.now_ms,
                                                                    move_first_reg);
                                        end
                                        ph_next = P_3;
                                    end
                                    else
                                    begin
                                        src_next = LST_MOVE;
                                        j_next   = '0;
                                        ph_next  = P_1;
                                    end
                                end
                                else if (is_menu_ctx(ctx_reg))
                                begin
                                    src_next = LST_MENU;
                                    j_next   = '0;
                                    ph_next  = P_1;
                                end
                                else if (c_new != CTX_MOVE && move_n_reg != '0)
                                begin
                                    src_next = LST_MOVE;
                                    j_next   = '0;
                                    ph_next  = P_1;
                                end
                                else
                                begin
                                    ph_next = P_3;
                                end
                            end
                            P_1:
                            begin
                                // fetch the next held key and push it onto the blocked list
                                if (j_reg == src_cnt)
                                begin
                                    if (src_reg == LST_MOVE)
                                    begin
                                        move_n_next = '0;
                                    end
                                    else
                                    begin
                                        menu_n_next = '0;
                                    end
                                    ph_next = P_3;
                                end
                                else
                                begin
                                    key_next = rd_data;
                                    go_scan  = 1'b1;
                                    go_drop  = 1'b1;
                                    go_sel   = LST_BLK;
                                    ph_next  = P_2;
                                end
                            end
                            P_2:
                            begin
                                if (blk_n_reg < BLK_CAP)
                                begin
                                    wr_en      = 1'b1;
                                    wr_sel     = LST_BLK;
                                    wr_addr    = blk_n_reg;
                                    blk_n_next = blk_n_reg + 1'b1;
                                end
                                j_next  = j_reg + 1'b1;
                                ph_next = P_1;
                            end
                            default:
                            begin
                                ctx_next   = c_new;
                                mflag_next = 1'b0;
                                nflag_next = 1'b0;
                                done       = 1'b1;
                            end
                        endcase
                    end

                    OP_KEY_DOWN:
                    begin
                        case (ph_reg)
                            P_START:
                            begin
                                go_scan = 1'b1;
                                go_sel  = LST_BLK;
                                ph_next = P_1;
                            end
                            P_1:
                            begin
                                if (found_reg)
                                begin
                                    done = 1'b1;
                                end
                                else if (req_reg.auto_repeat)
                                begin
                                    go_scan = 1'b1;
                                    go_sel  = LST_MOVE;
                                    ph_next = P_2;
                                end
                                else
                                begin
                                    ph_next = P_4;
                                end
                            end
                            P_2:
                            begin
                                if (found_reg)
                                begin
                                    done = 1'b1;
                                end
                                else
                                begin
                                    go_scan = 1'b1;
                                    go_sel  = LST_MENU;
                                    ph_next = P_3;
                                end
                            end
                            P_3:
                            begin
                                if (found_reg)
                                begin
                                    done = 1'b1;
                                end
                                else
                                begin
                                    ph_next = P_4;
                                end
                            end
                            P_4:
                            begin
                                if (req_reg.auto_repeat && ctx_reg == CTX_SAVE &&
                                    req_reg.key_class == CLS_HOME_END)
                                begin
                                    done = 1'b1;
                                end
                                else if (!ctl)
                                begin
                                    res.accepted = 1'b1;
                                    done         = 1'b1;
                                end
                                else if (req_reg.auto_repeat)
                                begin
                                    done = 1'b1;
                                end
                                else if (is_move_ctx(ctx_reg))
                                begin
                                    first_next = (move_n_reg == '0);
                                    go_scan    = 1'b1;
                                    go_drop    = 1'b1;
                                    go_sel     = LST_MOVE;
                                    ph_next    = P_5;
                                end
                                else
                                begin
                                    go_scan = 1'b1;
                                    go_drop = 1'b1;
                                    go_sel  = LST_MENU;
                                    ph_next = P_6;
                                end
                            end
                            P_5:
                            begin
                                // chord in battle: slide the new key in below the top
                                if (ctx_reg == CTX_BATTLE && !first_reg && move_n_reg != '0)
                                begin
                                    if (move_n_reg < MOVE_CAP)
                                    begin
                                        wr_en       = 1'b1;
                                        wr_sel      = LST_MOVE;
                                        wr_addr     = move_n_reg - 1'b1;
                                        wr2_en      = 1'b1;
                                        wr2_addr    = move_n_reg;
                                        move_n_next = move_n_reg + 1'b1;
                                    end
                                end
                                else if (move_n_reg < MOVE_CAP)
                                begin
                                    wr_en       = 1'b1;
                                    wr_sel      = LST_MOVE;
                                    wr_addr     = move_n_reg;
                                    move_n_next = move_n_reg + 1'b1;
                                end
                                if (first_reg)
                                begin
                                    move_due_next = sat_add(req_reg.now_ms, move_first_reg);
                                end
                                mflag_next   = 1'b1;
                                res.accepted = 1'b1;
                                done         = 1'b1;
                            end
                            default:
                            begin
                                if (menu_n_reg < MENU_CAP)
                                begin
                                    wr_en       = 1'b1;
                                    wr_sel      = LST_MENU;
                                    wr_addr     = menu_n_reg;
                                    menu_n_next = menu_n_reg + 1'b1;
                                end
                                menu_due_next = sat_add(req_reg.now_ms, menu_first_reg);
                                nflag_next    = 1'b1;
                                res.accepted  = 1'b1;
                                done          = 1'b1;
                            end
                        endcase
                    end

                    OP_KEY_UP:
                    begin
                        case (ph_reg)
                            P_START:
                            begin
                                go_scan = 1'b1;
                                go_drop = 1'b1;
                                go_sel  = LST_MOVE;
                                ph_next = P_1;
                            end
                            P_1:
                            begin
                                if (top_reg && move_n_reg != '0 && is_move_ctx(ctx_reg))
                                begin
                                    move_due_next = '0;
                                end
                                go_scan = 1'b1;
                                go_drop = 1'b1;
                                go_sel  = LST_MENU;
                                ph_next = P_2;
                            end
                            P_2:
                            begin
                                if (top_reg && menu_n_reg != '0 && is_menu_ctx(ctx_reg))
                                begin
                                    menu_due_next = sat_add(req_reg.now_ms, menu_first_reg);
                                end
                                go_scan = 1'b1;
                                go_drop = 1'b1;
                                go_sel  = LST_BLK;
                                ph_next = P_3;
                            end
                            default:
                            begin
                                done = 1'b1;
                            end
                        endcase
                    end

                    OP_POLL:
                    begin
                        if (is_move_ctx(ctx_reg) && !mflag_reg &&
                            req_reg.now_ms >= move_due_reg && move_n_reg != '0)
                        begin
                            res.move_repeat_valid = 1'b1;
                            res.repeat_key        = rd_data;
                        end
                        if (is_menu_ctx(ctx_reg) && !nflag_reg &&
                            req_reg.now_ms >= menu_due_reg && menu_n_reg != '0)
                        begin
                            res.menu_repeat_valid = 1'b1;
                            res.repeat_key        = rd_data;
                            menu_due_next = sat_add(req_reg.now_ms, menu_gap_reg);
                        end
                        done = 1'b1;
                    end

                    OP_WAIT:
                    begin
                        if (is_menu_ctx(ctx_reg) && menu_n_reg != '0)
                        begin
                            res.wait_valid = 1'b1;
                            if (menu_due_reg > req_reg.now_ms)
                            begin
                                res.wait_ms = menu_due_reg - req_reg.now_ms;
                            end
                        end
                        done = 1'b1;
                    end

                    OP_CONTROLS:
                    begin
                        res.accepted = ctl;
                        done         = 1'b1;
                    end

                    default:
                    begin
                        done = 1'b1;
                    end
                endcase
            end

            S_SCAN:
            begin
                // one entry a cycle: find the key, then pull later entries down
                if (idx_reg == sel_cnt)
                begin
                    top_next = found_reg && (pos_reg == sel_cnt - 1'b1);
                    if (found_reg && drop_reg)
                    begin
                        case (sel_reg)
                            LST_MOVE: move_n_next = move_n_reg - 1'b1;
                            LST_MENU: menu_n_next = menu_n_reg - 1'b1;
                            default:  blk_n_next  = blk_n_reg - 1'b1;
                        endcase
                    end
                    state_next = S_CTRL;
                end
                else
                begin
                    if (!found_reg && rd_data == key_reg)
                    begin
                        found_next = 1'b1;
                        pos_next   = idx_reg;
                    end
                    else if (found_reg && drop_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_sel  = sel_reg;
                        wr_addr = idx_reg - 1'b1;
                        wr_data = rd_data;
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_OUT:
            begin
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (go_scan)
        begin
            sel_next   = go_sel;
            drop_next  = go_drop;
            idx_next   = '0;
            found_next = 1'b0;
            state_next = S_SCAN;
        end
        if (done)
        begin
            rsp_next   = res;
            state_next = S_OUT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            move_n_reg     <= '0;
            menu_n_reg     <= '0;
            blk_n_reg      <= '0;
            ctx_reg        <= CTX_NONE;
            move_due_reg   <= '0;
            menu_due_reg   <= '0;
            mflag_reg      <= 1'b0;
            nflag_reg      <= 1'b0;
            move_first_reg <= RST_MOVE_FIRST;
            menu_first_reg <= RST_MENU_FIRST;
            menu_gap_reg   <= RST_MENU_GAP;
        end
        else
        begin
            state_reg    <= state_next;
            move_n_reg   <= move_n_next;
            menu_n_reg   <= menu_n_next;
            blk_n_reg    <= blk_n_next;
            ctx_reg      <= ctx_next;
            move_due_reg <= move_due_next;
            menu_due_reg <= menu_due_next;
            mflag_reg    <= mflag_next;
            nflag_reg    <= nflag_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_MOVE_FIRST: move_first_reg <= cfg_data;
                    REG_MENU_FIRST: menu_first_reg <= cfg_data;
                    REG_MENU_GAP:   menu_gap_reg   <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    // payload and sequencer working registers: no reset needed
    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        rsp_reg   <= rsp_next;
        key_reg   <= key_next;
        ph_reg    <= ph_next;
        sel_reg   <= sel_next;
        src_reg   <= src_next;
        drop_reg  <= drop_next;
        found_reg <= found_next;
        top_reg   <= top_next;
        first_reg <= first_next;
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        j_reg     <= j_next;
    end

    // list storage: one write port, plus a second on the movement stack for chords
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_sel == LST_MOVE)
        begin
            move_mem[wr_addr[MVW-1:0]] <= wr_data;
        end
        if (wr2_en)
        begin
            move_mem[wr2_addr[MVW-1:0]] <= wr2_data;
        end
        if (wr_en && wr_sel == LST_MENU)
        begin
            menu_mem[wr_addr[MNW-1:0]] <= wr_data;
        end
        if (wr_en && wr_sel == LST_BLK)
        begin
            blk_mem[wr_addr[BLW-1:0]] <= wr_data;
        end
    end

endmodule
